FILE: sv/tcw_pkg.sv
// package: shared types, codes and constants of the text console writer
package tcw_pkg;

    localparam int unsigned COLUMNS_DEF   = 80;
    localparam int unsigned ROWS_DEF      = 25;
    localparam int unsigned TERMINALS_DEF = 3;
    localparam int unsigned ADDR_W        = 13;

    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] RETURN_CODE  = 8'h0D;
    localparam logic [7:0] ATTR_RESET   = 8'h04;

    localparam logic [2:0] OP_PUT   = 3'd0;
    localparam logic [2:0] OP_BACK  = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] character;
        logic [1:0] terminal;
        logic [6:0] column;
        logic [4:0] row;
    } t_in_word;

    typedef struct packed {
        logic [10:0] cursor_position;
        logic [7:0]  cell_character;
        logic [7:0]  cell_attribute;
    } t_out_word;

    // command from front to back
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_CELL,
        CMD_READ,
        CMD_CLEAR,
        CMD_SCROLL
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [12:0] addr;
        logic [7:0]  character;
        logic        scroll_after;
        logic [10:0] cursor_position;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CELL,
        BK_READ,
        BK_RDWAIT,
        BK_FILL,
        BK_SCR_RD,
        BK_SCR_WR,
        BK_OUT
    } t_bk_state;

endpackage

FILE: sv/tcw_front.sv
// front end: cursor tracking and classification of input words into jobs
module tcw_front #(
    parameter int unsigned COLUMNS   = tcw_pkg::COLUMNS_DEF,
    parameter int unsigned ROWS      = tcw_pkg::ROWS_DEF,
    parameter int unsigned TERMINALS = tcw_pkg::TERMINALS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcw_pkg::t_in_word i_word,
    input  logic              i_fire,
    output tcw_pkg::t_job     o_job
);
    localparam int unsigned CW = $clog2(COLUMNS);
    localparam int unsigned RW = $clog2(ROWS);
    localparam int unsigned TW = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

    logic [CW-1:0] r_col [TERMINALS];
    logic [RW-1:0] r_row [TERMINALS];

    logic [TW-1:0] term;
    logic [CW-1:0] cc, nc;
    logic [RW-1:0] cr, nr;
    logic          in_range, nl, wrap;
    logic [12:0]   pos_addr, cell_addr;
    tcw_pkg::t_job job;

    always_comb begin
        if (32'(i_word.terminal) >= TERMINALS) term = TW'(TERMINALS - 1);
        else term = TW'(i_word.terminal);
    end

    assign cc = r_col[term];
    assign cr = r_row[term];
    assign in_range = (32'(i_word.column) < COLUMNS) && (32'(i_word.row) < ROWS);
    assign cell_addr = 13'(32'(i_word.row) * COLUMNS + 32'(i_word.column));
    assign pos_addr = 13'(32'(cr) * COLUMNS + 32'(cc));

    always_comb begin
        nc   = cc;
        nr   = cr;
        nl   = 1'b0;
        wrap = 1'b0;
        job  = '0;
        job.cmd = tcw_pkg::CMD_NONE;
        job.character = i_word.character;
        unique case (i_word.operation)
            tcw_pkg::OP_PUT: begin
                if (i_word.character == tcw_pkg::NEWLINE_CODE ||
                    i_word.character == tcw_pkg::RETURN_CODE) begin
                    nl = 1'b1;
                end else begin
                    job.cmd  = tcw_pkg::CMD_CELL;
                    job.addr = pos_addr;
                    if (32'(cc) + 1 >= COLUMNS) nl = 1'b1;
                    else nc = cc + CW'(1);
                end
            end
            tcw_pkg::OP_BACK: begin
                if (cc != '0 || cr != '0) begin
                    if (cc == '0) begin
                        nc = CW'(COLUMNS - 1);
                        nr = cr - RW'(1);
                    end else begin
                        nc = cc - CW'(1);
                    end
                    job.cmd = tcw_pkg::CMD_CELL;
                    job.character = tcw_pkg::SPACE_CODE;
                    job.addr = 13'(32'(nr) * COLUMNS + 32'(nc));
                end
            end
            tcw_pkg::OP_CLEAR: begin
                job.cmd = tcw_pkg::CMD_CLEAR;
                nc = '0;
                nr = '0;
            end
            tcw_pkg::OP_WRITE: begin
                if (in_range) begin
                    job.cmd  = tcw_pkg::CMD_CELL;
                    job.addr = cell_addr;
                end
            end
            tcw_pkg::OP_READ: begin
                if (in_range) begin
                    job.cmd  = tcw_pkg::CMD_READ;
                    job.addr = cell_addr;
                end
            end
            default: ;
        endcase
        if (nl) begin
            nc = '0;
            if (32'(cr) >= ROWS - 1) begin
                wrap = 1'b1;
                nr = RW'(ROWS - 1);
            end else begin
                nr = cr + RW'(1);
            end
        end
        if (wrap) begin
            if (job.cmd == tcw_pkg::CMD_CELL) job.scroll_after = 1'b1;
            else job.cmd = tcw_pkg::CMD_SCROLL;
        end
        job.cursor_position = 11'(32'(nr) * COLUMNS + 32'(nc));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TERMINALS; t++) begin
                r_col[t] <= '0;
                r_row[t] <= '0;
            end
        end else if (i_fire) begin
            r_col[term] <= nc;
            r_row[term] <= nr;
        end
    end

    assign o_job = job;
endmodule

FILE: sv/tcw_queue.sv
// small job queue between front and back
module tcw_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcw_pkg::t_job i_data,
    input  logic          i_pop,
    output tcw_pkg::t_job o_data,
    output logic          o_empty,
    output logic          o_full
);
    localparam int unsigned AW = $clog2(DEPTH);
    tcw_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (32'(r_wp) == DEPTH - 1) ? '0 : r_wp + AW'(1);
            if (i_pop)  r_rp <= (32'(r_rp) == DEPTH - 1) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (32'(r_cnt) == DEPTH);
endmodule

FILE: sv/tcw_back.sv
// back end: screen store, clearing pass, scroll sweep and result register
module tcw_back #(
    parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_attr,
    input  tcw_pkg::t_job      i_job,
    input  logic               i_job_valid,
    output logic               o_job_pop,
    output logic               o_busy_init,
    output logic               o_valid,
    input  logic               i_stall,
    output tcw_pkg::t_out_word o_word
);
    localparam int unsigned CELLS = COLUMNS * ROWS;
    localparam int unsigned AW = tcw_pkg::ADDR_W;

    logic [15:0] r_mem [2**AW];
    logic [15:0] r_rd;
    logic [AW-1:0] r_ptr, n_ptr;
    tcw_pkg::t_job r_job, n_job;
    tcw_pkg::t_bk_state r_st, n_st;
    logic r_init, n_init;
    logic r_ov, n_ov;
    tcw_pkg::t_out_word r_out, n_out;

    logic          we;
    logic [AW-1:0] wa, ra;
    logic [15:0]   wd;

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rd <= r_mem[ra];
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            tcw_pkg::BK_IDLE:
                if (!r_init && i_job_valid && !r_ov) begin
                    unique case (i_job.cmd)
                        tcw_pkg::CMD_CELL:   n_st = tcw_pkg::BK_CELL;
                        tcw_pkg::CMD_READ:   n_st = tcw_pkg::BK_READ;
                        tcw_pkg::CMD_CLEAR:  n_st = tcw_pkg::BK_FILL;
                        tcw_pkg::CMD_SCROLL: n_st = tcw_pkg::BK_SCR_RD;
                        default:             n_st = tcw_pkg::BK_OUT;
                    endcase
                end
            tcw_pkg::BK_CELL:
                n_st = r_job.scroll_after ? tcw_pkg::BK_SCR_RD : tcw_pkg::BK_OUT;
            tcw_pkg::BK_READ:   n_st = tcw_pkg::BK_RDWAIT;
            tcw_pkg::BK_RDWAIT: n_st = tcw_pkg::BK_OUT;
            tcw_pkg::BK_FILL:
                if (32'(r_ptr) == CELLS - 1) n_st = r_init ? tcw_pkg::BK_IDLE : tcw_pkg::BK_OUT;
            tcw_pkg::BK_SCR_RD: n_st = tcw_pkg::BK_SCR_WR;
            tcw_pkg::BK_SCR_WR:
                if (32'(r_ptr) == CELLS - 1) n_st = tcw_pkg::BK_OUT;
                else n_st = tcw_pkg::BK_SCR_RD;
            tcw_pkg::BK_OUT: n_st = tcw_pkg::BK_IDLE;
            default: n_st = tcw_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        n_ptr  = r_ptr;
        n_job  = r_job;
        n_init = r_init;
        n_ov   = r_ov && i_stall;
        n_out  = r_out;
        we = 1'b0;
        wa = r_job.addr;
        wd = {i_attr, r_job.character};
        ra = r_job.addr;
        o_job_pop = 1'b0;
        unique case (r_st)
            tcw_pkg::BK_IDLE: begin
                n_ptr = '0;
                if (!r_init && i_job_valid && !r_ov) begin
                    n_job = i_job;
                    o_job_pop = 1'b1;
                end
            end
            tcw_pkg::BK_CELL: begin
                we = 1'b1;
                n_ptr = '0;
            end
            tcw_pkg::BK_FILL: begin
                we = 1'b1;
                wa = r_ptr;
                wd = {r_init ? 8'h00 : i_attr, tcw_pkg::SPACE_CODE};
                n_ptr = r_ptr + AW'(1);
                if (32'(r_ptr) == CELLS - 1) n_init = 1'b0;
            end
            tcw_pkg::BK_SCR_RD: begin
                ra = AW'(32'(r_ptr) + COLUMNS);
            end
            tcw_pkg::BK_SCR_WR: begin
                we = 1'b1;
                wa = r_ptr;
                if (32'(r_ptr) >= CELLS - COLUMNS) wd = {i_attr, tcw_pkg::SPACE_CODE};
                else wd = {i_attr, r_rd[7:0]};
                n_ptr = r_ptr + AW'(1);
            end
            tcw_pkg::BK_OUT: begin
                n_ov = 1'b1;
                n_out.cursor_position = r_job.cursor_position;
                n_out.cell_character  = (r_job.cmd == tcw_pkg::CMD_READ) ? r_rd[7:0] : 8'h00;
                n_out.cell_attribute  = (r_job.cmd == tcw_pkg::CMD_READ) ? r_rd[15:8] : 8'h00;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= tcw_pkg::BK_FILL;
            r_init <= 1'b1;
            r_ov   <= 1'b0;
            r_ptr  <= '0;
        end else begin
            r_st   <= n_st;
            r_init <= n_init;
            r_ov   <= n_ov;
            r_ptr  <= n_ptr;
        end
        r_job <= n_job;
        r_out <= n_out;
    end

    assign o_valid     = r_ov;
    assign o_word      = r_out;
    assign o_busy_init = r_init;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_stall |=> r_ov && $stable(r_out))
        else $error("result dropped while stalled");
    a_no_job_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !o_job_pop)
        else $error("job taken during clearing pass");
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == tcw_pkg::BK_OUT |-> !r_ov)
        else $error("result overwritten");
endmodule

FILE: sv/text_console_writer.sv
// top level of the text console writer
//
// usage: input words (operation, character, terminal, column, row) enter on
// i_valid / o_stall; one result word per input leaves on o_valid / i_stall
// with the cursor position and, for read cell, the cell contents.
// the front end tracks the cursors and classifies each word into a job for
// the back end; a two-entry job queue sits between them.
// a clear screen walks the screen store cell by cell, and a scroll reads
// and rewrites it cell by cell, blanking the last row; a put char that
// wraps past the last row writes its cell first and then scrolls.
// the back end takes its next job the cycle after the result word leaves,
// so it works on one job at a time and jobs do not overlap.
// reset: cursors go home, the attribute register goes to 0x04 and a
// clearing pass fills all ROWS*COLUMNS cells with spaces of attribute zero;
// input words queue up meanwhile but no job starts until it ends.
// when the receiver stalls the result register holds and the back end waits;
// the front keeps taking words until the job queue is full.
// the attribute register is written on i_cfg_valid / o_cfg_ready.
module text_console_writer #(
    parameter int unsigned COLUMNS   = tcw_pkg::COLUMNS_DEF,
    parameter int unsigned ROWS      = tcw_pkg::ROWS_DEF,
    parameter int unsigned TERMINALS = tcw_pkg::TERMINALS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  tcw_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_stall,
    output tcw_pkg::t_out_word o_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);
    logic [7:0]    r_attr;
    logic          fire, q_full, q_empty, pop, busy_init;
    tcw_pkg::t_job job_in, job_out;

    // attribute register, always writable
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_attr <= tcw_pkg::ATTR_RESET;
        else if (i_cfg_valid) r_attr <= i_cfg_data;
    end

    assign o_stall = q_full;
    assign fire    = i_valid && !q_full;

    tcw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS), .TERMINALS(TERMINALS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_word(i_word), .i_fire(fire),
        .o_job(job_in)
    );

    tcw_queue #(.DEPTH(2)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(fire), .i_data(job_in),
        .i_pop(pop), .o_data(job_out), .o_empty(q_empty), .o_full(q_full)
    );

    tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_attr(r_attr), .i_job(job_out),
        .i_job_valid(!q_empty), .o_job_pop(pop), .o_busy_init(busy_init),
        .o_valid(o_valid), .i_stall(i_stall), .o_word(o_word)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("pop from empty job queue");
    a_init_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy_init |-> !o_valid)
        else $error("result during clearing pass");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> o_stall)
        else $error("input accepted into full queue");
endmodule
